>>> src/cfb_pkg.sv
// Shared types, constants and the CRC5 byte update for the command frame builder.
package cfb_pkg;

	localparam int MaxFrameBytes = 32;
	localparam int QueueDepth = 4;
	localparam int QueueAw = 2;

	localparam logic [7:0] SyncFirst = 8'h55;
	localparam logic [7:0] SyncSecond = 8'hAA;
	localparam logic [4:0] CrcPreset = 5'h1F;
	localparam logic [4:0] CrcPoly = 5'h05;
	localparam logic [7:0] LenAdd = 8'd3;
	localparam logic [8:0] FrameOverhead = 9'd5;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PAYLOAD = 1'b1;

	localparam logic [1:0] JOB_REJECT = 2'd0;
	localparam logic [1:0] JOB_HEAD = 2'd1;
	localparam logic [1:0] JOB_DATA = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] first;
		logic [7:0] lenb;
		logic [4:0] crc;
		logic close;
	} job_t;

	function automatic logic [4:0] crc_feed(input logic [4:0] crc, input logic [7:0] b);
		logic [4:0] c;
		logic fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = b[i] ^ c[4];
			c = {c[3:0], 1'b0} ^ (fb ? CrcPoly : 5'd0);
		end
		return c;
	endfunction

endpackage

>>> src/cfb_front.sv
// Front part: accepts input items, tracks frame state and the CRC, and queues output jobs.
module cfb_front (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic command,
	input  logic [7:0] header_byte,
	input  logic [4:0] payload_length,
	input  logic [7:0] data_byte,
	output logic push,
	output cfb_pkg::job_t job
);

	logic [4:0] crc_q;
	logic [4:0] bytes_left_q;
	logic in_frame_q;
	logic discarding_q;

	logic [7:0] lenb;
	logic oversize;
	logic [4:0] head_crc;
	logic [4:0] data_crc;
	logic [4:0] left_dec;

	assign lenb = {3'b000, payload_length} + cfb_pkg::LenAdd;
	assign oversize = ({4'b0000, payload_length} + cfb_pkg::FrameOverhead)
		> 9'(cfb_pkg::MaxFrameBytes);
	assign head_crc = cfb_pkg::crc_feed(cfb_pkg::crc_feed(cfb_pkg::CrcPreset, header_byte), lenb);
	assign data_crc = cfb_pkg::crc_feed(crc_q, data_byte);
	assign left_dec = 5'(bytes_left_q - 5'd1);

	always_comb begin
		push = 1'b0;
		job.kind = cfb_pkg::JOB_DATA;
		job.first = data_byte;
		job.lenb = lenb;
		job.crc = data_crc;
		job.close = (left_dec == 5'd0);
		if (accept) begin
			if (command == cfb_pkg::CMD_START) begin
				push = 1'b1;
				job.first = header_byte;
				if (oversize) begin
					job.kind = cfb_pkg::JOB_REJECT;
				end else begin
					job.kind = cfb_pkg::JOB_HEAD;
					job.crc = head_crc;
					job.close = (payload_length == 5'd0);
				end
			end else if (!discarding_q && in_frame_q) begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= cfb_pkg::CrcPreset;
			bytes_left_q <= 5'd0;
			in_frame_q <= 1'b0;
			discarding_q <= 1'b0;
		end else if (accept) begin
			if (command == cfb_pkg::CMD_START) begin
				bytes_left_q <= payload_length;
				if (oversize) begin
					in_frame_q <= 1'b0;
					discarding_q <= (payload_length != 5'd0);
				end else begin
					crc_q <= head_crc;
					in_frame_q <= (payload_length != 5'd0);
					discarding_q <= 1'b0;
				end
			end else if (discarding_q) begin
				bytes_left_q <= left_dec;
				if (left_dec == 5'd0) discarding_q <= 1'b0;
			end else if (in_frame_q) begin
				crc_q <= data_crc;
				bytes_left_q <= left_dec;
				if (left_dec == 5'd0) in_frame_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/cfb_queue.sv
// Short job queue between the front and back parts.
module cfb_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cfb_pkg::job_t push_job,
	input  logic pop,
	output cfb_pkg::job_t head,
	output logic empty,
	output logic full
);

	cfb_pkg::job_t mem_q [cfb_pkg::QueueDepth];
	logic [cfb_pkg::QueueAw-1:0] wr_ptr_q;
	logic [cfb_pkg::QueueAw-1:0] rd_ptr_q;
	logic [cfb_pkg::QueueAw:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == (cfb_pkg::QueueAw+1)'(cfb_pkg::QueueDepth));
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/cfb_back.sv
// Back part: steps through the head job and presents one frame byte per item.
module cfb_back (
	input  logic clk,
	input  logic arst_n,
	input  cfb_pkg::job_t head,
	input  logic empty,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] out_byte,
	output logic run_last,
	output logic frame_end,
	output logic rejected
);

	localparam logic [2:0] STEP_SYNC1 = 3'd0;
	localparam logic [2:0] STEP_SYNC2 = 3'd1;
	localparam logic [2:0] STEP_HDR = 3'd2;
	localparam logic [2:0] STEP_LEN = 3'd3;
	localparam logic [2:0] STEP_CRC = 3'd4;

	logic [2:0] step_q;
	logic take;

	assign out_valid = !empty;
	assign take = out_valid && !out_stall;
	assign pop = take && run_last;

	always_comb begin
		out_byte = 8'h00;
		run_last = 1'b0;
		frame_end = 1'b0;
		rejected = 1'b0;
		case (head.kind)
			cfb_pkg::JOB_REJECT: begin
				run_last = 1'b1;
				rejected = 1'b1;
			end
			cfb_pkg::JOB_HEAD: begin
				case (step_q)
					STEP_SYNC1: out_byte = cfb_pkg::SyncFirst;
					STEP_SYNC2: out_byte = cfb_pkg::SyncSecond;
					STEP_HDR: out_byte = head.first;
					STEP_LEN: begin
						out_byte = head.lenb;
						run_last = !head.close;
					end
					default: begin
						out_byte = {3'b000, head.crc};
						run_last = 1'b1;
						frame_end = 1'b1;
					end
				endcase
			end
			default: begin
				if (step_q == STEP_SYNC1) begin
					out_byte = head.first;
					run_last = !head.close;
				end else begin
					out_byte = {3'b000, head.crc};
					run_last = 1'b1;
					frame_end = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_SYNC1;
		end else if (take) begin
			if (run_last) step_q <= STEP_SYNC1;
			else if (head.kind == cfb_pkg::JOB_HEAD && step_q == STEP_LEN) step_q <= STEP_CRC;
			else step_q <= step_q + 3'd1;
		end
	end

endmodule

>>> src/crc5_command_frame_builder_core.sv
// Top level of the CRC5 command frame builder.
// Input channel (in_valid/in_stall): command 0 starts a frame with header_byte and
// payload_length, command 1 carries one payload byte in data_byte.
// Output channel (out_valid/out_stall): one frame byte per item in out_byte, with
// run_last on the last byte caused by an input item, frame_end on the CRC byte and
// rejected on the single zero byte that answers an oversized start.
// A start gives 0x55, 0xAA, header, payload_length + 3, and with no payload the CRC
// byte; each payload byte is passed through, the last one followed by the CRC byte.
// An item's job is registered in the job queue before its first byte is presented.
// Throughput: one input item per cycle while the job queue is not full; one output
// byte per cycle while out_stall is low. The front queues one job per start and per
// payload byte of an open frame in a four-entry job queue; a start job gives four or
// five output bytes, and in_stall rises only when the queue is full.
// Payload items with no open frame, and those of a rejected frame, are taken and
// give no output.
// Reset empties the queue, closes any frame and presets the CRC to all ones.
// When the receiver stalls, the current byte holds and the queue fills behind it.
module crc5_command_frame_builder_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic command,
	input  logic [7:0] header_byte,
	input  logic [4:0] payload_length,
	input  logic [7:0] data_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] out_byte,
	output logic run_last,
	output logic frame_end,
	output logic rejected
);

	logic accept;
	logic push;
	logic pop;
	logic empty;
	logic full;
	cfb_pkg::job_t push_job;
	cfb_pkg::job_t head;

	assign in_stall = full;
	assign accept = in_valid && !in_stall;

	cfb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.command(command),
		.header_byte(header_byte),
		.payload_length(payload_length),
		.data_byte(data_byte),
		.push(push),
		.job(push_job)
	);

	cfb_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full)
	);

	cfb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last),
		.frame_end(frame_end),
		.rejected(rejected)
	);

endmodule

>>> src/cfb_checker.sv
// Port-level assertions for the command frame builder, bound to the top level.
module cfb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] out_byte,
	input logic run_last,
	input logic frame_end,
	input logic rejected
);

	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last && !rejected)
		else $error("frame_end without run_last");

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> out_byte == 8'h00 && run_last && !frame_end)
		else $error("malformed rejection item");

	a_crc_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> out_byte[7:5] == 3'b000)
		else $error("CRC byte has high bits set");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last)
			&& $stable(frame_end) && $stable(rejected))
		else $error("stalled output item changed");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output pending");

endmodule

bind crc5_command_frame_builder_core cfb_checker u_cfb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_byte(out_byte),
	.run_last(run_last),
	.frame_end(frame_end),
	.rejected(rejected)
);
